// ===== src/quad_rate_control_mixer_unit_assert.svh =====
// assertion macros shared by the checker
`ifndef QUAD_RATE_CONTROL_MIXER_UNIT_ASSERT_SVH
`define QUAD_RATE_CONTROL_MIXER_UNIT_ASSERT_SVH

// checked outside reset
`define QRCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qrcm assertion failed");

// checked at every edge, reset included
`define QRCM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("qrcm reset assertion failed");

`endif

// ===== src/qrcm_pkg.sv =====
`timescale 1ns / 1ps
package qrcm_pkg;

  localparam int unsigned DataInW  = 112;
  localparam int unsigned DataOutW = 128;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 18;

  // 1/(2*arm) in Q16 and 1/(4*drag ratio) scaled to the mixer lsb
  localparam logic [18:0] Inv2LQ16  = 19'd192753;
  localparam logic [21:0] Inv4KAt40 = 22'd1024000;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_MASS       = 4'd0,
    CFG_INERTIA_XY = 4'd1,
    CFG_INERTIA_Z  = 4'd2,
    CFG_GAIN_XY    = 4'd3,
    CFG_GAIN_Z     = 4'd4,
    CFG_THRUST_MIN = 4'd5,
    CFG_THRUST_MAX = 4'd6,
    CFG_COEFF_INV  = 4'd7
  } cfg_idx_e;

endpackage

// ===== src/quad_rate_control_mixer_unit.sv =====
`timescale 1ns / 1ps
// Quadrotor body-rate controller with a fixed X motor mixer.
// Input word on s_axis: tdata holds thrust_cmd, rate_cmd_x/y/z and
// rate_meas_x/y/z, tuser holds rate_mode_active. Each word gives one result
// word on m_axis: four clamped rotor thrusts then four rotor speeds.
// Configuration registers are written over cfg_* (index, data); writes are
// always taken, indexes above 7 are ignored. Write only while idle.
// The pipeline has six stages for force, torque, mixer and radicand, six stages
// of the square root (three root bits per stage, four lanes) and one output
// register.
// Throughput is one word per cycle while m_axis_tready stays high.
// Every stage has its own valid bit and loads when it is empty or the next
// stage moves, so a stalled receiver fills the pipeline bubble by bubble;
// s_axis_tready falls only when all 13 stages hold words. Nothing is lost
// or repeated under a stall.
// Reset clears all valid bits and loads the register reset values.
module quad_rate_control_mixer_unit #(
  parameter int unsigned SqrtBitsPerStage = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // thrust_cmd, rate_cmd_x, rate_cmd_y, rate_cmd_z, rate_meas_x, rate_meas_y, rate_meas_z
  input  logic [qrcm_pkg::DataInW-1:0]   s_axis_tdata,
  // rate_mode_active
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // rotor_thrust_0..3, rotor_speed_0..3
  output logic [qrcm_pkg::DataOutW-1:0]  m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qrcm_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [qrcm_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int unsigned RootW   = 17;
  localparam int unsigned RadW    = 2 * RootW;
  localparam int unsigned RemW    = RootW + 5;
  localparam int unsigned SqStg   = (RootW + SqrtBitsPerStage - 1) / SqrtBitsPerStage;
  localparam int unsigned NStage  = 6 + SqStg + 1;

  // configuration
  logic [15:0] mass_q, ixy_q, iz_q, tmin_q, tmax_q;
  logic [9:0]  gxy_q, gz_q;
  logic [17:0] tci_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= 16'd2990;
      ixy_q  <= 16'd7340;
      iz_q   <= 16'd12583;
      gxy_q  <= 10'd100;
      gz_q   <= 10'd10;
      tmin_q <= 16'd614;
      tmax_q <= 16'd14336;
      tci_q  <= 18'd116978;
    end else if (cfg_valid) begin
      case (qrcm_pkg::cfg_idx_e'(cfg_addr))
        qrcm_pkg::CFG_MASS:       mass_q <= cfg_data[15:0];
        qrcm_pkg::CFG_INERTIA_XY: ixy_q  <= cfg_data[15:0];
        qrcm_pkg::CFG_INERTIA_Z:  iz_q   <= cfg_data[15:0];
        qrcm_pkg::CFG_GAIN_XY:    gxy_q  <= cfg_data[9:0];
        qrcm_pkg::CFG_GAIN_Z:     gz_q   <= cfg_data[9:0];
        qrcm_pkg::CFG_THRUST_MIN: tmin_q <= cfg_data[15:0];
        qrcm_pkg::CFG_THRUST_MAX: tmax_q <= cfg_data[15:0];
        qrcm_pkg::CFG_COEFF_INV:  tci_q  <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid chain and per-stage load enables
  logic [NStage-1:0] v_q;
  logic [NStage:0]   rdy;
  logic [NStage-1:0] vin;

  assign rdy[NStage] = m_axis_tready;
  assign vin[0]      = s_axis_tvalid;
  for (genvar k = 0; k < NStage; k++) begin : g_ctl
    assign rdy[k] = !v_q[k] || rdy[k+1];
    if (k > 0) begin : g_vin
      assign vin[k] = v_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= vin[k];
      end
    end
  end
  assign s_axis_tready = rdy[0];

  // stage 1: input products
  logic               act1_q;
  logic [31:0]        mt1_q;
  logic [25:0]        jkxy1_q, jkz1_q;
  logic signed [16:0] err1_q [3];
  logic signed [15:0] w1_q [3];
  logic signed [32:0] jw1_q [3];
  logic signed [15:0] cin [3];
  logic signed [15:0] win [3];

  for (genvar i = 0; i < 3; i++) begin : g_in
    assign cin[i] = s_axis_tdata[16*(i+1) +: 16];
    assign win[i] = s_axis_tdata[16*(i+4) +: 16];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      act1_q  <= s_axis_tuser;
      mt1_q   <= 32'(mass_q) * 32'(s_axis_tdata[15:0]);
      jkxy1_q <= 26'(ixy_q) * 26'(gxy_q);
      jkz1_q  <= 26'(iz_q) * 26'(gz_q);
      for (int i = 0; i < 3; i++) begin
        err1_q[i] <= 17'(cin[i]) - 17'(win[i]);
        w1_q[i]   <= win[i];
        jw1_q[i]  <= $signed({1'b0, (i == 2) ? iz_q : ixy_q}) * 33'(win[i]);
      end
    end
  end

  // stage 2: force clamp, torque and gyroscopic products
  logic               act2_q;
  logic [17:0]        f2_q;
  logic signed [43:0] tq2_q [3];
  logic signed [48:0] gp2_q [6];
  logic [23:0]        f24;
  logic [17:0]        lo4, hi4, fcl;

  assign f24 = mt1_q[31:8];
  assign lo4 = {tmin_q, 2'b00};
  assign hi4 = {tmax_q, 2'b00};
  always_comb begin
    if (f24 < 24'(lo4)) begin
      fcl = lo4;
    end else if (f24 > 24'(hi4)) begin
      fcl = hi4;
    end else begin
      fcl = f24[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      act2_q   <= act1_q;
      f2_q     <= act1_q ? fcl : 18'd0;
      tq2_q[0] <= $signed({1'b0, jkxy1_q}) * 44'(err1_q[0]);
      tq2_q[1] <= $signed({1'b0, jkxy1_q}) * 44'(err1_q[1]);
      tq2_q[2] <= $signed({1'b0, jkz1_q}) * 44'(err1_q[2]);
      gp2_q[0] <= 49'(w1_q[1]) * 49'(jw1_q[2]);
      gp2_q[1] <= 49'(w1_q[2]) * 49'(jw1_q[1]);
      gp2_q[2] <= 49'(w1_q[2]) * 49'(jw1_q[0]);
      gp2_q[3] <= 49'(w1_q[0]) * 49'(jw1_q[2]);
      gp2_q[4] <= 49'(w1_q[0]) * 49'(jw1_q[1]);
      gp2_q[5] <= 49'(w1_q[1]) * 49'(jw1_q[0]);
    end
  end

  // stage 3: torque sum at 2^-24 N m
  logic [17:0]        f3_q;
  logic signed [38:0] t3_q [3];
  logic signed [54:0] tsum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = (55'(tq2_q[i]) <<< 10) + 55'(gp2_q[2*i]) - 55'(gp2_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      f3_q <= f2_q;
      for (int i = 0; i < 3; i++) begin
        t3_q[i] <= act2_q ? tsum[i][54:16] : 39'sd0;
      end
    end
  end

  // stage 4: mixer products
  logic signed [44:0] base4_q;
  logic signed [57:0] a4_q, b4_q;
  logic signed [60:0] d4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      base4_q <= $signed({1'b0, f3_q, 26'd0});
      a4_q    <= 58'(t3_q[0]) * $signed({39'd0, qrcm_pkg::Inv2LQ16});
      b4_q    <= 58'(t3_q[1]) * $signed({39'd0, qrcm_pkg::Inv2LQ16});
      d4_q    <= 61'(t3_q[2]) * $signed({39'd0, qrcm_pkg::Inv4KAt40});
    end
  end

  // stage 5: rotor thrusts
  logic [15:0]        th5_q [4];
  logic signed [61:0] rsum [4];
  logic signed [33:0] rsh [4];
  logic [15:0]        thc [4];

  always_comb begin
    rsum[0] = 62'(base4_q) - 62'(b4_q) + 62'(d4_q);
    rsum[1] = 62'(base4_q) + 62'(a4_q) - 62'(d4_q);
    rsum[2] = 62'(base4_q) + 62'(b4_q) + 62'(d4_q);
    rsum[3] = 62'(base4_q) - 62'(a4_q) - 62'(d4_q);
    for (int i = 0; i < 4; i++) begin
      rsh[i] = rsum[i][61:28];
      if (rsh[i] < $signed({18'd0, tmin_q})) begin
        thc[i] = tmin_q;
      end else if (rsh[i] > $signed({18'd0, tmax_q})) begin
        thc[i] = tmax_q;
      end else begin
        thc[i] = rsh[i][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      th5_q <= thc;
    end
  end

  // stage 6: radicand
  logic [15:0]     th6_q [4];
  logic [RadW-1:0] rad6_q [4];

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      th6_q <= th5_q;
      for (int i = 0; i < 4; i++) begin
        rad6_q[i] <= RadW'(th5_q[i]) * RadW'(tci_q);
      end
    end
  end

  // square root stages, SqrtBitsPerStage root bits each
  logic [15:0]      sth_q  [SqStg][4];
  logic [RadW-1:0]  srad_q [SqStg][4];
  logic [RemW-1:0]  srem_q [SqStg][4];
  logic [RootW-1:0] sroot_q[SqStg][4];

  for (genvar j = 0; j < SqStg; j++) begin : g_sq
    logic [15:0]      th_in [4];
    logic [RadW-1:0]  rd_in [4];
    logic [RemW-1:0]  rm_in [4];
    logic [RootW-1:0] rt_in [4];
    logic [RadW-1:0]  rd [4];
    logic [RemW-1:0]  rm [4];
    logic [RootW-1:0] rt [4];
    logic [RemW-1:0]  trial [4];

    if (j == 0) begin : g_first
      assign th_in = th6_q;
      assign rd_in = rad6_q;
      for (genvar l = 0; l < 4; l++) begin : g_clr
        assign rm_in[l] = '0;
        assign rt_in[l] = '0;
      end
    end else begin : g_next
      assign th_in = sth_q[j-1];
      assign rd_in = srad_q[j-1];
      assign rm_in = srem_q[j-1];
      assign rt_in = sroot_q[j-1];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        rd[l] = rd_in[l];
        rm[l] = rm_in[l];
        rt[l] = rt_in[l];
        trial[l] = '0;
        for (int s = 0; s < SqrtBitsPerStage; s++) begin
          if (j * SqrtBitsPerStage + s < RootW) begin
            rm[l] = {rm[l][RemW-3:0], rd[l][RadW-1:RadW-2]};
            rd[l] = {rd[l][RadW-3:0], 2'b00};
            trial[l] = {{(RemW-RootW-2){1'b0}}, rt[l], 2'b01};
            if (rm[l] >= trial[l]) begin
              rm[l] = rm[l] - trial[l];
              rt[l] = {rt[l][RootW-2:0], 1'b1};
            end else begin
              rt[l] = {rt[l][RootW-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[6+j]) begin
        sth_q[j]   <= th_in;
        srad_q[j]  <= rd;
        srem_q[j]  <= rm;
        sroot_q[j] <= rt;
      end
    end
  end

  // output register
  logic [15:0] oth_q [4];
  logic [15:0] osp_q [4];

  always_ff @(posedge clk_i) begin
    if (rdy[NStage-1]) begin
      oth_q <= sth_q[SqStg-1];
      for (int l = 0; l < 4; l++) begin
        osp_q[l] <= sroot_q[SqStg-1][l][RootW-1] ? 16'hFFFF : sroot_q[SqStg-1][l][15:0];
      end
    end
  end

  assign m_axis_tvalid = v_q[NStage-1];
  for (genvar l = 0; l < 4; l++) begin : g_out
    assign m_axis_tdata[16*l +: 16]     = oth_q[l];
    assign m_axis_tdata[16*(l+4) +: 16] = osp_q[l];
  end

endmodule

// ===== src/qrcm_checker.sv =====
`timescale 1ns / 1ps
`include "quad_rate_control_mixer_unit_assert.svh"
module qrcm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [qrcm_pkg::DataOutW-1:0] m_axis_tdata
);

  `QRCM_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
  `QRCM_ASSERT(a_zero_thrust, (m_axis_tvalid && m_axis_tdata[15:0] == 16'd0) |-> (m_axis_tdata[79:64] == 16'd0))
  `QRCM_ASSERT(a_same_thrust, (m_axis_tvalid && m_axis_tdata[15:0] == m_axis_tdata[47:32]) |-> (m_axis_tdata[79:64] == m_axis_tdata[111:96]))
  `QRCM_ASSERT_RST(a_reset_idle, !rst_ni |-> !m_axis_tvalid)

endmodule

bind quad_rate_control_mixer_unit qrcm_checker u_qrcm_checker (.*);

// ===== test/quad_rate_control_mixer_checker.sv =====
`timescale 1ns / 1ps
module quad_rate_control_mixer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [qrcm_pkg::DataInW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [qrcm_pkg::DataOutW-1:0] m_axis_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [qrcm_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [qrcm_pkg::CfgDataW-1:0] cfg_data,
  output int                            fail_cnt,
  output int                            pending_cnt,
  output int                            checked_cnt
);
  import qrcm_pkg::*;

  logic [15:0] mass_q, inertia_xy_q, inertia_z_q, thrust_min_q, thrust_max_q;
  logic [9:0]  gain_xy_q, gain_z_q;
  logic [17:0] coeff_inv_q;
  logic [DataOutW-1:0] rotor_words_q[$];

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [DataOutW-1:0] mix_rotors(logic mode, logic [DataInW-1:0] d);
    logic signed [127:0] force_v, lo, hi, base, a, b, dz, th;
    logic signed [127:0] c[3], w[3], jm[3], kg[3], jw[3], gyro[3], t24[3], r[4];
    logic [63:0] sp;
    logic [DataOutW-1:0] res;
    lo = thrust_min_q;
    hi = thrust_max_q;
    force_v = 0;
    for (int i = 0; i < 3; i++) t24[i] = 0;
    if (mode) begin
      force_v = (mass_q * d[15:0]) >> 8;
      if (force_v < 4 * lo) force_v = 4 * lo;
      else if (force_v > 4 * hi) force_v = 4 * hi;
      for (int i = 0; i < 3; i++) begin
        c[i] = $signed(d[16 + 16 * i +: 16]);
        w[i] = $signed(d[64 + 16 * i +: 16]);
      end
      jm[0] = inertia_xy_q; jm[1] = inertia_xy_q; jm[2] = inertia_z_q;
      kg[0] = gain_xy_q; kg[1] = gain_xy_q; kg[2] = gain_z_q;
      for (int i = 0; i < 3; i++) jw[i] = jm[i] * w[i];
      gyro[0] = w[1] * jw[2] - w[2] * jw[1];
      gyro[1] = w[2] * jw[0] - w[0] * jw[2];
      gyro[2] = w[0] * jw[1] - w[1] * jw[0];
      for (int i = 0; i < 3; i++)
        t24[i] = (jm[i] * kg[i] * (c[i] - w[i]) * 1024 + gyro[i]) >>> 16;
    end
    base = force_v <<< 26;
    a = t24[0] * $signed({1'b0, Inv2LQ16});
    b = t24[1] * $signed({1'b0, Inv2LQ16});
    dz = t24[2] * $signed({1'b0, Inv4KAt40});
    r[0] = base - b + dz;
    r[1] = base + a - dz;
    r[2] = base + b + dz;
    r[3] = base - a - dz;
    for (int i = 0; i < 4; i++) begin
      th = r[i] >>> 28;
      if (th < lo) th = lo;
      else if (th > hi) th = hi;
      sp = root_floor(64'(th[15:0]) * coeff_inv_q);
      if (sp > 64'hFFFF) sp = 64'hFFFF;
      res[16 * i +: 16] = th[15:0];
      res[64 + 16 * i +: 16] = sp[15:0];
    end
    return res;
  endfunction

  assign pending_cnt = rotor_words_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q       <= 16'd2990;
      inertia_xy_q <= 16'd7340;
      inertia_z_q  <= 16'd12583;
      gain_xy_q    <= 10'd100;
      gain_z_q     <= 10'd10;
      thrust_min_q <= 16'd614;
      thrust_max_q <= 16'd14336;
      coeff_inv_q  <= 18'd116978;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_e'(cfg_addr))
        CFG_MASS:       mass_q       <= cfg_data[15:0];
        CFG_INERTIA_XY: inertia_xy_q <= cfg_data[15:0];
        CFG_INERTIA_Z:  inertia_z_q  <= cfg_data[15:0];
        CFG_GAIN_XY:    gain_xy_q    <= cfg_data[9:0];
        CFG_GAIN_Z:     gain_z_q     <= cfg_data[9:0];
        CFG_THRUST_MIN: thrust_min_q <= cfg_data[15:0];
        CFG_THRUST_MAX: thrust_max_q <= cfg_data[15:0];
        CFG_COEFF_INV:  coeff_inv_q  <= cfg_data;
        default: ;
      endcase
    end
  end

  initial begin
    fail_cnt = 0;
    checked_cnt = 0;
  end

  always @(posedge clk_i) begin
    logic [DataOutW-1:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        rotor_words_q.push_back(mix_rotors(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (rotor_words_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected output word %h", m_axis_tdata);
        end else begin
          want = rotor_words_q.pop_front();
          checked_cnt++;
          for (int i = 0; i < 8; i++) begin
            if (m_axis_tdata[16 * i +: 16] !== want[16 * i +: 16]) begin
              fail_cnt++;
              if (fail_cnt <= 10)
                $display("word %0d %s %0d: expected %0d got %0d", checked_cnt,
                         (i < 4) ? "thrust" : "speed", i % 4,
                         want[16 * i +: 16], m_axis_tdata[16 * i +: 16]);
            end
          end
        end
      end
    end
  end

endmodule

// ===== test/quad_rate_control_mixer_unit_tb.sv =====
`timescale 1ns / 1ps
module quad_rate_control_mixer_unit_tb;
  import qrcm_pkg::*;

  localparam logic [CfgAddrW-1:0] CfgIdxUnused = 4'd15;
  localparam int NumPhases = 5;
  localparam int WordsPerPhase = 300;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [DataInW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [DataOutW-1:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_data;
  int fail_cnt, pending_cnt, checked_cnt;
  int send_idle_pct, recv_stall_pct, sent_cnt;

  quad_rate_control_mixer_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data
  );

  quad_rate_control_mixer_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data,
    .fail_cnt, .pending_cnt, .checked_cnt
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(logic mode, logic [15:0] thr, logic [15:0] cx, logic [15:0] cy,
                           logic [15:0] cz, logic [15:0] wx, logic [15:0] wy,
                           logic [15:0] wz);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {wz, wy, wx, cz, cy, cx, thr};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // leaves the write request up; the caller drops it after the last write
  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_rate();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($signed($urandom_range(4000)) - 2000);
      2: return 16'($signed($urandom_range(200)) - 100);
      default: return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  task automatic send_random();
    logic [15:0] thr;
    thr = ($urandom_range(2) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(5000));
    send_word($urandom_range(9) != 0, thr, rand_rate(), rand_rate(), rand_rate(),
              rand_rate(), rand_rate(), rand_rate());
  endtask

  initial begin
    logic [CfgDataW-1:0] regs[8];
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_addr      <= CFG_MASS;
    cfg_data      <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent_cnt = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at reset settings
    send_word(1'b0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_word(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(1'b1, 16'd2560, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(1'b1, 16'd2560, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
    send_word(1'b1, 16'd2560, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(1'b1, 16'd2560, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(1'b1, 16'd2560, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(1'b1, 16'd2560, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    send_word(1'b1, 16'd2560, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(1'b1, 16'd2560, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
    send_word(1'b1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    drain();
    write_reg(CfgIdxUnused, 18'h3FFFF);
    cfg_valid <= 1'b0;
    send_word(1'b1, 16'd2560, 16'h0010, 16'hFFF0, 16'h0020, 16'h0000, 16'h0000, 16'h0000);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0: regs = '{2990, 7340, 12583, 100, 10, 614, 14336, 116978};
        1: regs = '{65535, 65535, 65535, 1023, 1023, 0, 65535, 262143};
        // low bound above high bound and zero speed coefficient
        2: regs = '{0, 0, 0, 0, 0, 40000, 1000, 0};
        3: regs = '{1, 1, 1, 1, 1, 65535, 65535, 1};
        default: begin
          for (int i = 0; i < 8; i++) regs[i] = 18'($urandom_range(65535));
          regs[3] = 18'($urandom_range(1023));
          regs[4] = 18'($urandom_range(1023));
          regs[7] = 18'($urandom_range(262143, 1));
        end
      endcase
      write_reg(CFG_MASS, regs[0]);
      write_reg(CFG_INERTIA_XY, regs[1]);
      write_reg(CFG_INERTIA_Z, regs[2]);
      write_reg(CFG_GAIN_XY, regs[3]);
      write_reg(CFG_GAIN_Z, regs[4]);
      write_reg(CFG_THRUST_MIN, regs[5]);
      write_reg(CFG_THRUST_MAX, regs[6]);
      write_reg(CFG_COEFF_INV, regs[7]);
      cfg_valid <= 1'b0;
      for (int k = 0; k < WordsPerPhase; k++) begin
        if (k % 75 == 0) begin
          case ((p + k / 75) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
          endcase
        end
        // hold off until the pipeline is empty
        if (k == WordsPerPhase / 2) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending_cnt != 0) @(posedge clk_i);
        end
        send_random();
      end
    end
    drain();

    $display("sent %0d words, checked %0d results", sent_cnt, checked_cnt);
    $display("covered reset, extreme and random register settings under four flow patterns");
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("quad_rate_control_mixer_unit_tb OK");
    end else begin
      $display("quad_rate_control_mixer_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("quad_rate_control_mixer_unit_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/qrcm_pkg.sv
src/quad_rate_control_mixer_unit.sv
src/qrcm_checker.sv
test/quad_rate_control_mixer_checker.sv
test/quad_rate_control_mixer_unit_tb.sv
